// ===== rtl/lbq_pkg.sv =====
// Shared types and constants of the level bucket queue.
// Used by the core, the level scanner and the port checker; depends on nothing.
package lbq_pkg;

  localparam int LEVELS    = 64;
  localparam int CAPACITY  = 1024;
  localparam int NODE_BITS = 16;
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int SLOT_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_MIN   = 2'd1;
  localparam logic [1:0] REQ_MAX   = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_LIMIT = 2'd3;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [NODE_BITS-1:0] node_id;
    logic [LVL_W-1:0]     node_level;
  } in_item_t;

  typedef struct packed {
    logic [NODE_BITS-1:0] out_node_id;
    logic [LVL_W-1:0]     out_level;
    logic [1:0]           status;
  } out_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] head;
    logic [SLOT_W-1:0] tail;
  } bkt_ent_t;

  typedef struct packed {
    logic             found;
    logic [LVL_W-1:0] level;
  } scan_res_t;

endpackage

// ===== rtl/lbq_scan.sv =====
// Priority encoder over the per-level occupancy flags of the bucket queue.
// Finds the lowest or highest occupied level inside the tracked window; uses lbq_pkg.
module lbq_scan (
  input  logic [lbq_pkg::LEVELS-1:0] flags,
  input  logic [lbq_pkg::LVL_W-1:0]  lo,
  input  logic [lbq_pkg::LVL_W-1:0]  hi,
  input  logic                       from_top,
  output lbq_pkg::scan_res_t         res
);
  import lbq_pkg::*;

  logic [LEVELS-1:0] masked;

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      masked[i] = flags[i] && (LVL_W'(i) >= lo) && (LVL_W'(i) <= hi);
    end
  end

  always_comb begin
    res.found = |masked;
    res.level = '0;
    if (from_top) begin
      for (int i = 0; i < LEVELS; i++) begin
        if (masked[i]) begin
          res.level = LVL_W'(i);
        end
      end
    end else begin
      for (int i = LEVELS - 1; i >= 0; i--) begin
        if (masked[i]) begin
          res.level = LVL_W'(i);
        end
      end
    end
  end

endmodule

// ===== rtl/level_bucket_queue_core.sv =====
// Top level of the level bucket queue: control, slot store, bucket table, free stack.
// Depends on lbq_pkg and lbq_scan.
//
// A request is taken when start is high and busy is low. A stored put passes S_LOOK and
// S_FETCH, a get that finds a node also S_COMMIT, and a clear, a refused put or a get
// on an empty queue only S_LOOK, set by the chain of registered memory reads from the
// bucket table to the slot store. The result appears for one cycle with out_strobe high,
// in the cycle right after busy falls, and a new request may be taken in that same cycle.
// The receiver cannot stall the result. A write of the level limit on the cfg channel is
// taken while the core is idle and start is low, and it also empties the queue; no
// clearing pass is needed.
module level_bucket_queue_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  lbq_pkg::in_item_t      in_item,
  output logic                   out_strobe,
  output lbq_pkg::out_item_t     out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [lbq_pkg::LVL_W-1:0] cfg_level_limit
);
  import lbq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_FETCH, S_COMMIT} state_t;

  state_t            state_r, state_nxt;
  in_item_t          req_r, req_nxt;
  logic [LVL_W-1:0]  limit_r, limit_nxt;
  logic [LEVELS-1:0] nonempty_r, nonempty_nxt;
  logic [CNT_W-1:0]  item_cnt_r, item_cnt_nxt;
  logic [CNT_W-1:0]  fresh_r, fresh_nxt;
  logic [CNT_W-1:0]  fptr_r, fptr_nxt;
  logic [LVL_W-1:0]  low_r, low_nxt;
  logic [LVL_W-1:0]  high_r, high_nxt;
  logic [LVL_W-1:0]  wlvl_r, wlvl_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  bkt_ent_t          bkt_mem [LEVELS];
  logic [NODE_BITS-1:0] node_mem [CAPACITY];
  logic [SLOT_W-1:0] next_mem [CAPACITY];
  logic [SLOT_W-1:0] free_mem [CAPACITY];

  bkt_ent_t             bkt_rd_r;
  logic [NODE_BITS-1:0] node_rd_r;
  logic [SLOT_W-1:0]    next_rd_r;
  logic [SLOT_W-1:0]    free_rd_r;

  logic [LVL_W-1:0]  bkt_raddr;
  logic              bkt_we;
  logic [LVL_W-1:0]  bkt_waddr;
  bkt_ent_t          bkt_wdata;
  logic              node_we;
  logic [SLOT_W-1:0] node_waddr;
  logic              next_we;
  logic [SLOT_W-1:0] next_waddr;
  logic [SLOT_W-1:0] next_wdata;
  logic              free_we;
  logic [SLOT_W-1:0] free_raddr;
  logic [CNT_W-1:0]  fptr_dec;

  scan_res_t         scan;
  logic              cfg_fire;

  lbq_scan u_scan (
    .flags    (nonempty_r),
    .lo       (low_r),
    .hi       (high_r),
    .from_top (req_r.req_type == REQ_MAX),
    .res      (scan)
  );

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE) && !start;
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign out_strobe = out_valid_r;
  assign out_item   = out_r;

  assign fptr_dec   = fptr_r - CNT_W'(1);
  assign free_raddr = fptr_dec[SLOT_W-1:0];
  assign bkt_raddr  = (req_r.req_type == REQ_PUT) ? req_r.node_level : scan.level;

  always_comb begin
    logic [SLOT_W-1:0] slot;
    logic              use_fresh;

    state_nxt     = state_r;
    req_nxt       = req_r;
    limit_nxt     = limit_r;
    nonempty_nxt  = nonempty_r;
    item_cnt_nxt  = item_cnt_r;
    fresh_nxt     = fresh_r;
    fptr_nxt      = fptr_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    wlvl_nxt      = wlvl_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    bkt_we        = 1'b0;
    bkt_waddr     = wlvl_r;
    bkt_wdata     = bkt_rd_r;
    node_we       = 1'b0;
    next_we       = 1'b0;
    next_waddr    = bkt_rd_r.tail;
    free_we       = 1'b0;
    use_fresh     = (fresh_r < CNT_W'(CAPACITY));
    slot          = use_fresh ? fresh_r[SLOT_W-1:0] : free_rd_r;
    node_waddr    = slot;
    next_wdata    = slot;

    case (state_r)
      S_IDLE: begin
        if (cfg_fire) begin
          limit_nxt    = cfg_level_limit;
          nonempty_nxt = '0;
          item_cnt_nxt = '0;
          fresh_nxt    = '0;
          fptr_nxt     = '0;
          low_nxt      = '0;
          high_nxt     = '0;
        end else if (start) begin
          req_nxt   = in_item;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        out_nxt = '0;
        case (req_r.req_type)
          REQ_PUT: begin
            wlvl_nxt = req_r.node_level;
            if (req_r.node_level > limit_r || int'(req_r.node_level) >= LEVELS) begin
              out_nxt.status = ST_LIMIT;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end else if (item_cnt_r == CNT_W'(CAPACITY)) begin
              out_nxt.status = ST_FULL;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end else begin
              state_nxt = S_FETCH;
            end
          end
          REQ_MIN, REQ_MAX: begin
            wlvl_nxt = scan.level;
            if (item_cnt_r == '0 || low_r > high_r || !scan.found) begin
              out_nxt.status = ST_EMPTY;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end else begin
              state_nxt = S_FETCH;
            end
          end
          default: begin
            nonempty_nxt  = '0;
            item_cnt_nxt  = '0;
            fresh_nxt     = '0;
            fptr_nxt      = '0;
            low_nxt       = '0;
            high_nxt      = '0;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        endcase
      end
      S_FETCH: begin
        if (req_r.req_type == REQ_PUT) begin
          node_we = 1'b1;
          bkt_we  = 1'b1;
          if (nonempty_r[wlvl_r]) begin
            next_we   = 1'b1;
            bkt_wdata = '{head: bkt_rd_r.head, tail: slot};
          end else begin
            bkt_wdata            = '{head: slot, tail: slot};
            nonempty_nxt[wlvl_r] = 1'b1;
          end
          if (item_cnt_r == '0) begin
            low_nxt  = wlvl_r;
            high_nxt = wlvl_r;
          end else begin
            if (wlvl_r < low_r) begin
              low_nxt = wlvl_r;
            end
            if (wlvl_r > high_r) begin
              high_nxt = wlvl_r;
            end
          end
          if (use_fresh) begin
            fresh_nxt = fresh_r + CNT_W'(1);
          end else begin
            fptr_nxt = fptr_dec;
          end
          item_cnt_nxt  = item_cnt_r + CNT_W'(1);
          out_nxt       = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (bkt_rd_r.head == bkt_rd_r.tail) begin
          nonempty_nxt[wlvl_r] = 1'b0;
        end else begin
          bkt_we    = 1'b1;
          bkt_wdata = '{head: next_rd_r, tail: bkt_rd_r.tail};
        end
        if (fptr_r < CNT_W'(CAPACITY)) begin
          free_we  = 1'b1;
          fptr_nxt = fptr_r + CNT_W'(1);
        end
        item_cnt_nxt = item_cnt_r - CNT_W'(1);
        if (req_r.req_type == REQ_MIN) begin
          low_nxt = wlvl_r;
        end else begin
          high_nxt = wlvl_r;
        end
        out_nxt.out_node_id = node_rd_r;
        out_nxt.out_level   = wlvl_r;
        out_nxt.status      = ST_OK;
        out_valid_nxt       = 1'b1;
        state_nxt           = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= LVL_W'(LEVELS - 1);
      nonempty_r  <= '0;
      item_cnt_r  <= '0;
      fresh_r     <= '0;
      fptr_r      <= '0;
      low_r       <= '0;
      high_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      limit_r     <= limit_nxt;
      nonempty_r  <= nonempty_nxt;
      item_cnt_r  <= item_cnt_nxt;
      fresh_r     <= fresh_nxt;
      fptr_r      <= fptr_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r  <= req_nxt;
    wlvl_r <= wlvl_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    bkt_rd_r <= bkt_mem[bkt_raddr];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= req_r.node_id;
    end
    node_rd_r <= node_mem[bkt_rd_r.head];
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    next_rd_r <= next_mem[bkt_rd_r.head];
  end

  always_ff @(posedge clk) begin
    if (free_we) begin
      free_mem[fptr_r[SLOT_W-1:0]] <= bkt_rd_r.head;
    end
    free_rd_r <= free_mem[free_raddr];
  end

endmodule

// ===== rtl/lbq_checker.sv =====
// Port-level checker for the level bucket queue core, attached by the bind below.
// Depends on lbq_pkg and sees only the top level's ports.
module lbq_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input lbq_pkg::in_item_t      in_item,
  input logic                   out_strobe,
  input lbq_pkg::out_item_t     out_item,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [lbq_pkg::LVL_W-1:0] cfg_level_limit
);
  import lbq_pkg::*;

  // Every accepted transaction makes the core busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // A result only follows a cycle of work.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without a preceding busy cycle");

  // Results are single-cycle pulses, one per transaction.
  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  // Only a successful get carries a node id or a level.
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.status != ST_OK |->
      out_item.out_node_id == '0 && out_item.out_level == '0)
    else $error("refused transaction returned a nonzero payload");

endmodule

bind level_bucket_queue_core lbq_checker u_lbq_checker (.*);

// ===== sim/lbq_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the level bucket queue: watches the request, result and limit
// channels, predicts each result and compares it with what the core returns. Uses lbq_pkg.
module lbq_result_checker
  import lbq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_strobe,
  input  out_item_t out_item,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic [LVL_W-1:0] cfg_level_limit,
  output int        fail_count,
  output int        pending
);

  logic [NODE_BITS-1:0] slot_id    [CAPACITY];
  logic [SLOT_W-1:0]    slot_link  [CAPACITY];
  logic [SLOT_W-1:0]    spare_slot [CAPACITY];
  logic [SLOT_W-1:0]    first_slot [LEVELS];
  logic [SLOT_W-1:0]    last_slot  [LEVELS];
  logic [LEVELS-1:0]    occupied;
  int spare_top;
  int held;
  int floor_lvl;
  int ceil_lvl;
  int level_limit;
  int mismatches;
  out_item_t awaited_results [16];
  logic [3:0] wr_ptr;
  logic [3:0] rd_ptr;
  logic [3:0] backlog;
  out_item_t want;

  function automatic void empty_buckets();
    occupied = '0;
    for (int i = 0; i < CAPACITY; i++) spare_slot[i] = SLOT_W'(i);
    spare_top = CAPACITY;
    held = 0;
    floor_lvl = 0;
    ceil_lvl = 0;
  endfunction

  function automatic out_item_t serve_request(in_item_t req);
    out_item_t res;
    int slot;
    int lvl;
    res = '0;
    case (req.req_type)
      REQ_PUT: begin
        lvl = int'(req.node_level);
        if (lvl > level_limit) begin
          res.status = ST_LIMIT;
        end else if (held >= CAPACITY || spare_top == 0) begin
          res.status = ST_FULL;
        end else begin
          spare_top--;
          slot = int'(spare_slot[spare_top]);
          slot_id[slot] = req.node_id;
          slot_link[slot] = '0;
          if (occupied[lvl]) begin
            slot_link[last_slot[lvl]] = SLOT_W'(slot);
          end else begin
            first_slot[lvl] = SLOT_W'(slot);
            occupied[lvl] = 1'b1;
          end
          last_slot[lvl] = SLOT_W'(slot);
          if (held == 0) begin
            floor_lvl = lvl;
            ceil_lvl = lvl;
          end else begin
            if (lvl < floor_lvl) floor_lvl = lvl;
            if (lvl > ceil_lvl) ceil_lvl = lvl;
          end
          held++;
          res.status = ST_OK;
        end
      end
      REQ_MIN, REQ_MAX: begin
        res.status = ST_EMPTY;
        if (held != 0 && ceil_lvl < LEVELS) begin
          for (int step = 0; step <= ceil_lvl - floor_lvl && res.status != ST_OK;
               step++) begin
            lvl = (req.req_type == REQ_MIN) ? floor_lvl + step : ceil_lvl - step;
            if (occupied[lvl]) begin
              slot = int'(first_slot[lvl]);
              res.out_node_id = slot_id[slot];
              res.out_level = LVL_W'(lvl);
              res.status = ST_OK;
              if (SLOT_W'(slot) == last_slot[lvl]) occupied[lvl] = 1'b0;
              else first_slot[lvl] = slot_link[slot];
              if (spare_top < CAPACITY) begin
                spare_slot[spare_top] = SLOT_W'(slot);
                spare_top++;
              end
              held--;
              if (req.req_type == REQ_MIN) floor_lvl = lvl;
              else ceil_lvl = lvl;
            end
          end
        end
      end
      default: begin
        empty_buckets();
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      empty_buckets();
      level_limit = LEVELS - 1;
      mismatches = 0;
      wr_ptr = '0;
      rd_ptr = '0;
    end else begin
      if (out_strobe) begin
        if (wr_ptr == rd_ptr) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result id=%h level=%0d status=%0d", $realtime,
                     out_item.out_node_id, out_item.out_level, out_item.status);
        end else begin
          want = awaited_results[rd_ptr];
          rd_ptr = rd_ptr + 4'd1;
          if (out_item.out_node_id !== want.out_node_id || out_item.out_level !== want.out_level
              || out_item.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch expected id=%h level=%0d status=%0d, %s",
                       $realtime, want.out_node_id, want.out_level, want.status,
                       $sformatf("got id=%h level=%0d status=%0d", out_item.out_node_id,
                                 out_item.out_level, out_item.status));
          end
        end
      end
      if (start && !busy) begin
        awaited_results[wr_ptr] = serve_request(in_item);
        wr_ptr = wr_ptr + 4'd1;
      end
      if (cfg_valid && cfg_ready) begin
        level_limit = int'(cfg_level_limit);
        empty_buckets();
      end
    end
    backlog = wr_ptr - rd_ptr;
    fail_count <= mismatches;
    pending <= int'(backlog);
  end

endmodule

// ===== sim/tb_level_bucket_queue_core.sv =====
`timescale 1ns / 1ps
// Testbench top for level_bucket_queue_core: directed and random request transactions,
// limit writes and sender gaps. Depends on lbq_pkg, the core and lbq_result_checker.
module tb_level_bucket_queue_core;
  import lbq_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic out_strobe;
  out_item_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [LVL_W-1:0] cfg_level_limit;
  int fail_count;
  int pending;
  int cycle_count = 0;
  int gap_pct = 0;
  int cur_limit = LEVELS - 1;

  level_bucket_queue_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_level_limit(cfg_level_limit)
  );

  lbq_result_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_level_limit(cfg_level_limit),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic in_item_t request(logic [1:0] kind, int id, int lvl);
    in_item_t item;
    item.req_type = kind;
    item.node_id = NODE_BITS'(id);
    item.node_level = LVL_W'(lvl);
    return item;
  endfunction

  task automatic issue(in_item_t item);
    int idle;
    start <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
    idle = 0;
    while (idle < 40 && $urandom_range(99) < gap_pct) idle++;
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_limit(int value);
    drain();
    cfg_valid <= 1'b1;
    cfg_level_limit <= LVL_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_limit = value;
  endtask

  task automatic random_requests(int count);
    int pick;
    int lvl;
    logic [1:0] kind;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      kind = (pick < 48) ? REQ_PUT : (pick < 72) ? REQ_MIN : (pick < 97) ? REQ_MAX : REQ_CLEAR;
      lvl = ($urandom_range(99) < 85) ? $urandom_range(cur_limit) : $urandom_range(LEVELS - 1);
      issue(request(kind, $urandom, lvl));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_level_limit = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(request(REQ_MIN, 0, 0));
    issue(request(REQ_MAX, 16'hffff, 63));
    issue(request(REQ_PUT, 16'h0000, 0));
    issue(request(REQ_PUT, 16'hffff, 63));
    issue(request(REQ_PUT, 16'h1234, 63));
    issue(request(REQ_PUT, 16'ha5a5, 17));
    issue(request(REQ_PUT, 16'h5a5a, 17));
    issue(request(REQ_MAX, 0, 0));
    issue(request(REQ_MAX, 0, 0));
    issue(request(REQ_MIN, 0, 0));
    issue(request(REQ_MIN, 0, 0));
    issue(request(REQ_MAX, 0, 0));
    issue(request(REQ_MIN, 0, 0));
    issue(request(REQ_PUT, 16'h00ff, 40));
    issue(request(REQ_CLEAR, 16'hffff, 63));
    issue(request(REQ_MAX, 0, 0));
    write_limit(20);
    issue(request(REQ_PUT, 16'h0101, 21));
    issue(request(REQ_PUT, 16'h0202, 20));
    issue(request(REQ_PUT, 16'h0303, 63));
    issue(request(REQ_PUT, 16'h0404, 0));
    issue(request(REQ_MAX, 0, 0));
    issue(request(REQ_MIN, 0, 0));

    write_limit(63);
    random_requests(250);
    gap_pct = 83;
    write_limit(0);
    random_requests(100);
    gap_pct = 11;
    write_limit(37);
    random_requests(100);
    drain();
    random_requests(100);

    gap_pct = 0;
    write_limit(50);
    repeat (CAPACITY + 6) issue(request(REQ_PUT, $urandom, $urandom_range(50)));
    repeat (6) issue(request(REQ_PUT, $urandom, $urandom_range(LEVELS - 1)));
    repeat (12) issue(request($urandom_range(1) ? REQ_MIN : REQ_MAX, $urandom, $urandom));
    issue(request(REQ_CLEAR, $urandom, $urandom));
    issue(request(REQ_MIN, $urandom, $urandom));

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
